### hw/rtl/edt_pkg.sv
// ----------------------------------------------------------------------------
// edt_pkg
// Shared types and constants for the node distance block.
// ----------------------------------------------------------------------------
package edt_pkg;

   localparam int unsigned MAX_NODES_DEF = 1024;
   localparam int unsigned FRAC_BITS_DEF = 8;

   localparam int unsigned NODE_W  = 10;
   localparam int unsigned COORD_W = 32;
   localparam int unsigned COST_W  = 25;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   // opcode carried on req_tuser
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 2;

   // request tdata: first_node, second_node, x_coord, y_coord
   localparam int unsigned REQ_DATA_W = 88;
   // response tdata: pair_first, pair_second, cost
   localparam int unsigned RSP_DATA_W = 48;

   // one query with its coordinates fetched
   typedef struct packed {
      logic [NODE_W-1:0]         pair_first;
      logic [NODE_W-1:0]         pair_second;
      logic signed [COORD_W-1:0] xa;
      logic signed [COORD_W-1:0] ya;
      logic signed [COORD_W-1:0] xb;
      logic signed [COORD_W-1:0] yb;
   } job_type;

endpackage

### hw/rtl/edt_front.sv
// ----------------------------------------------------------------------------
// edt_front
// Takes request beats, writes stores into the coordinate memories and
// fetches both nodes of a query, then hands the query to the job queue.
// ----------------------------------------------------------------------------
module edt_front #(
   parameter int unsigned MAX_NODES = edt_pkg::MAX_NODES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [edt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            q_full,
   output logic                            q_push,
   output edt_pkg::job_type                q_job
);
   import edt_pkg::*;

   localparam int unsigned AW = $clog2(MAX_NODES);

   logic [COORD_W-1:0] x_mem [MAX_NODES];
   logic [COORD_W-1:0] y_mem [MAX_NODES];

   logic               accept;
   logic [NODE_W-1:0]  na;
   logic [NODE_W-1:0]  nb;
   logic [16:0]        na_ext;
   logic [16:0]        nb_ext;
   logic [AW-1:0]      addr_a;
   logic [AW-1:0]      addr_b;
   logic               na_ok;
   logic               nb_ok;

   logic               pend_ff;
   logic               pend_in;
   logic [NODE_W-1:0]  na_ff;
   logic [NODE_W-1:0]  nb_ff;
   logic               na_ok_ff;
   logic               nb_ok_ff;
   logic [COORD_W-1:0] xa_ff;
   logic [COORD_W-1:0] ya_ff;
   logic [COORD_W-1:0] xb_ff;
   logic [COORD_W-1:0] yb_ff;

   assign na     = req_tdata[9:0];
   assign nb     = req_tdata[19:10];
   assign na_ext = 17'(na);
   assign nb_ext = 17'(nb);
   assign addr_a = na_ext[AW-1:0];
   assign addr_b = nb_ext[AW-1:0];
   assign na_ok  = na_ext < 17'(MAX_NODES);
   assign nb_ok  = nb_ext < 17'(MAX_NODES);

   // one query in flight through the read stage at a time
   assign req_tready = !pend_ff && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign pend_in    = accept && (req_tuser == OP_QUERY);

   always_ff @(posedge clock) begin
      if (accept && (req_tuser == OP_STORE) && na_ok) begin
         x_mem[addr_a] <= req_tdata[51:20];
         y_mem[addr_a] <= req_tdata[83:52];
      end
      if (pend_in) begin
         xa_ff    <= x_mem[addr_a];
         ya_ff    <= y_mem[addr_a];
         xb_ff    <= x_mem[addr_b];
         yb_ff    <= y_mem[addr_b];
         na_ff    <= na;
         nb_ff    <= nb;
         na_ok_ff <= na_ok;
         nb_ok_ff <= nb_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // nodes beyond the table read as the origin
   assign q_push            = pend_ff;
   assign q_job.pair_first  = na_ff;
   assign q_job.pair_second = nb_ff;
   assign q_job.xa          = na_ok_ff ? xa_ff : '0;
   assign q_job.ya          = na_ok_ff ? ya_ff : '0;
   assign q_job.xb          = nb_ok_ff ? xb_ff : '0;
   assign q_job.yb          = nb_ok_ff ? yb_ff : '0;

endmodule

### hw/rtl/edt_queue.sv
// ----------------------------------------------------------------------------
// edt_queue
// Short job queue between the fetch side and the distance unit.
// ----------------------------------------------------------------------------
module edt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  edt_pkg::job_type push_job,
   input  logic             pop,
   output edt_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);
   import edt_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### hw/rtl/edt_back.sv
// ----------------------------------------------------------------------------
// edt_back
// Distance unit: squares the differences on one shared multiplier, takes a
// bit-per-cycle square root of four times the sum and rounds half up.
// ----------------------------------------------------------------------------
module edt_back #(
   parameter int unsigned FRAC_BITS = edt_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  edt_pkg::job_type               q_head,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [edt_pkg::RSP_DATA_W-1:0] rsp_tdata  // pair_first, pair_second, cost
);
   import edt_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQX  = 3'd1;
   localparam logic [2:0] ST_SQY  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_ROOT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int unsigned ROOT_W = 34;
   localparam int unsigned RAD_W  = 2 * ROOT_W;
   localparam int unsigned REM_W  = ROOT_W + 3;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [5:0]          cnt_ff;
   logic                out_valid_ff;
   logic                slot_free;

   logic [NODE_W-1:0]   first_ff;
   logic [NODE_W-1:0]   second_ff;
   logic [31:0]         dx_ff;
   logic [31:0]         dy_ff;
   logic [63:0]         prod_ff;
   logic [63:0]         sqx_ff;
   logic [RAD_W-1:0]    rad_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [NODE_W-1:0]   out_first_ff;
   logic [NODE_W-1:0]   out_second_ff;
   logic [COST_W-1:0]   out_cost_ff;

   logic signed [32:0]  dx_raw;
   logic signed [32:0]  dy_raw;
   logic [32:0]         dx_mag;
   logic [32:0]         dy_mag;
   logic [31:0]         mul_a;
   logic [65:0]         add_sum;
   logic [REM_W-1:0]    rem_sh;
   logic [REM_W-1:0]    trial;
   logic                take;
   logic [ROOT_W:0]     rnd_sum;
   logic [ROOT_W:0]     rnd;
   logic [COST_W-1:0]   cost;

   assign dx_raw = {q_head.xa[31], q_head.xa} - {q_head.xb[31], q_head.xb};
   assign dy_raw = {q_head.ya[31], q_head.ya} - {q_head.yb[31], q_head.yb};
   assign dx_mag = dx_raw[32] ? 33'(-dx_raw) : 33'(dx_raw);
   assign dy_mag = dy_raw[32] ? 33'(-dy_raw) : 33'(dy_raw);

   assign mul_a   = (state_ff == ST_SQX) ? dx_ff : dy_ff;
   assign add_sum = 66'(sqx_ff) + 66'(prod_ff);

   // restoring root, two radicand bits per step
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign take   = rem_sh >= trial;

   // root is floor(sqrt(4S)); half-up rounding of sqrt(S) / 2^F
   assign rnd_sum = {1'b0, root_ff} + ((ROOT_W + 1)'(1) << FRAC_BITS);
   assign rnd     = rnd_sum >> (FRAC_BITS + 1);
   assign cost    = (rnd > (ROOT_W + 1)'(COST_MAX)) ? COST_MAX : rnd[COST_W-1:0];

   assign slot_free = !out_valid_ff || rsp_tready;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_ADD;
         ST_ADD:  state_in = ST_ROOT;
         ST_ROOT: if (cnt_ff == 6'(ROOT_W - 1)) state_in = ST_DONE;
         ST_DONE: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         first_ff  <= q_head.pair_first;
         second_ff <= q_head.pair_second;
         dx_ff     <= dx_mag[31:0];
         dy_ff     <= dy_mag[31:0];
      end
      if ((state_ff == ST_SQX) || (state_ff == ST_SQY)) begin
         prod_ff <= 64'(mul_a) * 64'(mul_a);
      end
      if (state_ff == ST_SQY) begin
         sqx_ff <= prod_ff;
      end
      if (state_ff == ST_ADD) begin
         rad_ff  <= {add_sum, 2'b00};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (state_ff == ST_ROOT) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= take ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
      if ((state_ff == ST_DONE) && slot_free) begin
         out_first_ff  <= first_ff;
         out_second_ff <= second_ff;
         out_cost_ff   <= cost;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ROOT) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
         if ((state_ff == ST_DONE) && slot_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_cost_ff, out_second_ff, out_first_ff};

endmodule

### hw/rtl/euclid_distance_table.sv
// ----------------------------------------------------------------------------
// euclid_distance_table
// Node coordinate store with on-demand rounded Euclidean distance.
// ----------------------------------------------------------------------------
// Request channel (req_*): one beat per item. req_tuser is the opcode:
// store writes x and y of node first_node; query asks for the distance
// between first_node and second_node. A store gives no response.
// Response channel (rsp_*): one beat per query, in request order, carrying
// both node indices and the cost, round-half-up of the distance in whole
// units, saturated to 25 bits. Nodes at or beyond MAX_NODES read as (0,0);
// stores to them are dropped. Querying a node never stored is undefined.
// A store is written into memory as it is accepted. A query passes the fetch
// stage (memory read register), then the distance unit: squaring and sum on
// one shared 32x32 multiplier, the bit-per-cycle square root, then the load
// of the output register. The unit pops the next query only after that load.
// A two-entry job queue separates fetch from the distance unit, so stores and
// the next queries keep flowing while a result waits on rsp_tready, until the queue fills.
// Reset empties the queue and drops pending results; memory is not cleared.
// ----------------------------------------------------------------------------
module euclid_distance_table #(
   parameter int unsigned MAX_NODES = edt_pkg::MAX_NODES_DEF,
   parameter int unsigned FRAC_BITS = edt_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // first_node[9:0], second_node[19:10], x_coord[51:20], y_coord[83:52]
   input  logic [edt_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pair_first[9:0], pair_second[19:10], cost[44:20]
   output logic [edt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import edt_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;
   job_type q_in;
   job_type q_head;

   edt_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_in)
   );

   edt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in),
      .pop      (q_pop),
      .head_job (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   edt_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   a_query_queued: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_QUERY)) |=> q_push)
      else $error("query beat not queued");

   a_store_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_STORE)) |=> !q_push)
      else $error("store beat produced a job");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

### tb/euclid_distance_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euclid_distance_table_tb
// Stores node coordinates and queries pairwise rounded distances on the
// stream ports; every response is checked against a local distance model.
// ----------------------------------------------------------------------------
module euclid_distance_table_tb;
   import edt_pkg::*;

   localparam int FRAC = 8;

   typedef struct {
      logic              op;
      logic [NODE_W-1:0] na;
      logic [NODE_W-1:0] nb;
      logic [31:0]       xc;
      logic [31:0]       yc;
      bit                known;
      logic [COST_W-1:0] cost;
   } stim_row_type;

   typedef struct {
      logic [NODE_W-1:0] na;
      logic [NODE_W-1:0] nb;
      logic [COST_W-1:0] cost;
   } dist_beat_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = OP_STORE;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [31:0]   x_mem [MAX_NODES_DEF];
   logic [31:0]   y_mem [MAX_NODES_DEF];
   bit            written [MAX_NODES_DEF];
   dist_beat_type pending_dist [$];
   int            fail_cnt = 0;
   int            send_idle = 0;
   int            recv_idle = 0;
   stim_row_type  rows [$];

   euclid_distance_table DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [COST_W-1:0] euc_cost(logic [31:0] xa, logic [31:0] ya,
                                                   logic [31:0] xb, logic [31:0] yb);
      logic signed [33:0] dx, dy;
      logic [67:0] sum4, sq;
      logic [33:0] root, cand;
      logic [35:0] n;
      dx = $signed({{2{xa[31]}}, xa}) - $signed({{2{xb[31]}}, xb});
      dy = $signed({{2{ya[31]}}, ya}) - $signed({{2{yb[31]}}, yb});
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sum4 = ({34'd0, dx} * {34'd0, dx} + {34'd0, dy} * {34'd0, dy}) << 2;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = root | (34'd1 << b);
         sq = {34'd0, cand} * {34'd0, cand};
         if (sq <= sum4) root = cand;
      end
      n = ({2'b0, root} + (36'd1 << FRAC)) >> (FRAC + 1);
      return (n > COST_MAX) ? COST_MAX : n[COST_W-1:0];
   endfunction

   // drive one beat and update the shadow store once it is taken
   task automatic send_beat(stim_row_type r);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= r.op;
      req_tdata  <= {4'd0, r.yc, r.xc, r.nb, r.na};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (r.op == OP_STORE) begin
         x_mem[r.na] = r.xc;
         y_mem[r.na] = r.yc;
         written[r.na] = 1;
      end else begin
         dist_beat_type e;
         e.na = r.na;
         e.nb = r.nb;
         e.cost = euc_cost(x_mem[r.na], y_mem[r.na], x_mem[r.nb], y_mem[r.nb]);
         if (r.known && e.cost != r.cost) begin
            $error("cost: expected %0d, actual %0d", r.cost, e.cost);
            fail_cnt++;
         end
         pending_dist.push_back(e);
      end
   endtask

   function automatic stim_row_type st(int n, logic [31:0] x, logic [31:0] y);
      stim_row_type r;
      r = '{OP_STORE, NODE_W'(n), '0, x, y, 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type qy(int a, int b, bit k, int c);
      stim_row_type r;
      r = '{OP_QUERY, NODE_W'(a), NODE_W'(b), $urandom, $urandom, k, COST_W'(c)};
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_dist.size() == 0) begin
               $error("unexpected response beat");
               fail_cnt++;
            end else begin
               dist_beat_type e;
               e = pending_dist.pop_front();
               if (rsp_tdata[9:0] !== e.na) begin
                  $error("pair_first: expected %0d, actual %0d", e.na, rsp_tdata[9:0]);
                  fail_cnt++;
               end
               if (rsp_tdata[19:10] !== e.nb) begin
                  $error("pair_second: expected %0d, actual %0d", e.nb, rsp_tdata[19:10]);
                  fail_cnt++;
               end
               if (rsp_tdata[44:20] !== e.cost) begin
                  $error("cost: expected %0d, actual %0d", e.cost, rsp_tdata[44:20]);
                  fail_cnt++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      stim_row_type r;
      int a, b, mode;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes of coordinates, largest distance, self distance, halves
      rows.push_back(st(0, 32'd0, 32'd0));
      rows.push_back(st(1, 32'd768, 32'd1024));
      rows.push_back(qy(0, 1, 1, 5));
      rows.push_back(qy(0, 0, 1, 0));
      rows.push_back(st(2, 32'd128, 32'd0));
      rows.push_back(qy(0, 2, 1, 1));        // exact half rounds up
      rows.push_back(st(3, 32'd127, 32'd0));
      rows.push_back(qy(3, 0, 1, 0));
      rows.push_back(st(1023, 32'h7FFFFFFF, 32'h7FFFFFFF));
      rows.push_back(st(1022, 32'h80000000, 32'h80000000));
      rows.push_back(qy(1023, 1022, 1, 23726566));
      rows.push_back(qy(1022, 1023, 1, 23726566));
      rows.push_back(qy(1023, 0, 1, 11863283));
      rows.push_back(st(4, 32'hFFFFFFFF, 32'h00000001));
      rows.push_back(qy(4, 0, 0, 0));
      rows.push_back(st(5, 32'h80000000, 32'h7FFFFFFF));
      rows.push_back(qy(5, 1023, 0, 0));
      rows.push_back(qy(4, 5, 0, 0));
      rows.push_back(st(5, 32'hFFFFFF00, 32'h00000100));
      rows.push_back(qy(5, 2, 0, 0));
      foreach (rows[i]) send_beat(rows[i]);
      for (int i = 0; i < 1030; i++) begin
         mode = i * 3 / 1030;
         send_idle = (mode == 0) ? 20 : (mode == 1) ? 85 : 0;
         recv_idle = (mode == 0) ? 85 : (mode == 1) ? 20 : 0;
         if ((i % 97) > 80) begin
            send_idle = 0;
            recv_idle = 0;
         end
         a = $urandom_range(1023);
         if (!written[a] || $urandom_range(2) == 0) begin
            // small coordinates most of the time so costs stay varied
            r = st(a, $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(8191)) - 4096,
                   $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(8191)) - 4096);
         end else begin
            do b = $urandom_range(1023); while (!written[b]);
            r = qy(a, b, 0, 0);
         end
         send_beat(r);
      end
      req_tvalid <= 0;
      recv_idle = 0;
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/edt_pkg.sv
hw/rtl/edt_front.sv
hw/rtl/edt_queue.sv
hw/rtl/edt_back.sv
hw/rtl/euclid_distance_table.sv
tb/euclid_distance_table_tb.sv
